/* sv/mvn_pkg.sv */
// Shared types, codes and constants of the mesh vertex normal block.
package mvn_pkg;

	// Default vertex store depth.
	localparam int MVN_VERTEX_COUNT = 4096;

	// Field widths.
	localparam int IDX_W  = 12;
	localparam int POS_W  = 24;
	localparam int SUM_W  = 32;
	localparam int NRM_W  = 16;
	localparam int EDGE_W = POS_W + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int VEC_W  = PROD_W + 1;

	// Largest Q1.15 magnitude.
	localparam logic [NRM_W-1:0] Q_MAX = 16'h7fff;

	// Item actions.
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_TRI  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// Result kinds.
	localparam logic KIND_FACE   = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] x;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] z;
	} sum_t;

	// Vector handed to the normalizer.
	typedef struct packed {
		logic                    start;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} norm_req_t;

	// Unit vector returned by the normalizer.
	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
	} norm_res_t;

	// Add a normal component into a sum, clamped to the 32-bit range.
	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
			input logic signed [NRM_W-1:0] b);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {{(SUM_W+1-NRM_W){b[NRM_W-1]}}, b};
		if (s[SUM_W:SUM_W-1] == 2'b01) begin
			return {1'b0, {(SUM_W-1){1'b1}}};
		end else if (s[SUM_W:SUM_W-1] == 2'b10) begin
			return {1'b1, {(SUM_W-1){1'b0}}};
		end
		return s[SUM_W-1:0];
	endfunction

endpackage

/* sv/mvn_norm.sv */
// Sequential vector normalizer: scaling, sum of squares, square root and division.
module mvn_norm import mvn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  norm_req_t req,
	output norm_res_t res
);

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQUARE, N_SQRT, N_DIVSET, N_DIV, N_DONE
	} nstate_t;

	nstate_t                  state_q;
	logic [VEC_W-1:0]         m_q [3];
	logic [2:0]               neg_q;
	logic [2*31-1:0]          sq_q;
	logic [63:0]              acc_q;
	logic [63:0]              n_q;
	logic [63:0]              root_q;
	logic [63:0]              bit_q;
	logic [31:0]              len_q;
	logic [31:0]              rem_q;
	logic [15:0]              lo_q;
	logic [15:0]              qt_q;
	logic [4:0]               cnt_q;
	logic [1:0]               ci_q;
	logic signed [NRM_W-1:0]  q_q [3];

	logic [VEC_W-1:0]  mx;
	logic [30:0]       msel;
	logic [30:0]       mdiv;
	logic [63:0]       trial;
	logic [47:0]       num;
	logic [32:0]       t;
	logic              ge;
	logic [15:0]       qn;
	logic [15:0]       qc;

	// Largest magnitude and operand selection.
	always_comb begin
		mx = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
		if (m_q[2] > mx) begin
			mx = m_q[2];
		end
		case (cnt_q[1:0])
			2'd0: msel = m_q[0][30:0];
			2'd1: msel = m_q[1][30:0];
			2'd2: msel = m_q[2][30:0];
			default: msel = '0;
		endcase
		case (ci_q)
			2'd0: mdiv = m_q[0][30:0];
			2'd1: mdiv = m_q[1][30:0];
			default: mdiv = m_q[2][30:0];
		endcase
		trial = root_q + bit_q;
		// The root stays in place through all three divisions.
		num = {2'b0, mdiv, 15'b0} + {17'b0, root_q[31:1]};
		t = {rem_q, lo_q[15]};
		ge = (t >= {1'b0, len_q});
		qn = {qt_q[14:0], ge};
		qc = (qn > Q_MAX) ? Q_MAX : qn;
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			case (state_q)
				N_IDLE: begin
					if (req.start) begin
						m_q[0] <= req.x[VEC_W-1] ? VEC_W'(-req.x) : req.x;
						m_q[1] <= req.y[VEC_W-1] ? VEC_W'(-req.y) : req.y;
						m_q[2] <= req.z[VEC_W-1] ? VEC_W'(-req.z) : req.z;
						neg_q <= {req.z[VEC_W-1], req.y[VEC_W-1], req.x[VEC_W-1]};
						q_q[0] <= '0;
						q_q[1] <= '0;
						q_q[2] <= '0;
						if (req.x == '0 && req.y == '0 && req.z == '0) begin
							state_q <= N_DONE;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					// Bring the largest magnitude into [2^30, 2^31).
					if (|mx[VEC_W-1:31]) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] >> 1;
						end
					end else if (!mx[30]) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] << 1;
						end
					end else begin
						cnt_q <= '0;
						sq_q <= '0;
						acc_q <= '0;
						state_q <= N_SQUARE;
					end
				end
				N_SQUARE: begin
					sq_q <= msel * msel;
					acc_q <= acc_q + 64'(sq_q);
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						n_q <= acc_q + 64'(sq_q);
						root_q <= '0;
						bit_q <= 64'd1 << 62;
						cnt_q <= '0;
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					// One result bit of the integer square root per cycle.
					if (n_q >= trial) begin
						n_q <= n_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						ci_q <= '0;
						state_q <= N_DIVSET;
					end
				end
				N_DIVSET: begin
					if (cnt_q == 5'd0) begin
						len_q <= root_q[31:0];
					end
					rem_q <= num[47:16];
					lo_q <= num[15:0];
					qt_q <= '0;
					cnt_q <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					// Restoring division, one quotient bit per cycle.
					rem_q <= ge ? 32'(t - {1'b0, len_q}) : t[31:0];
					lo_q <= lo_q << 1;
					qt_q <= qn;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						q_q[ci_q] <= neg_q[ci_q] ? NRM_W'(16'd0 - qc) : qc;
						if (ci_q == 2'd2) begin
							state_q <= N_DONE;
						end else begin
							ci_q <= ci_q + 2'd1;
							cnt_q <= 5'd1;
							state_q <= N_DIVSET;
						end
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	assign res.busy = (state_q != N_IDLE);
	assign res.done = (state_q == N_DONE);
	assign res.x    = q_q[0];
	assign res.y    = q_q[1];
	assign res.z    = q_q[2];

endmodule

/* sv/mesh_vertex_normals_top.sv */
// Top level of the mesh vertex normal block: vertex stores and item sequencer.
//
// Input channel (in_valid / in_stall) carries one item per transaction: a
// vertex load, a triangle, or a vertex normal read. Output channel
// (out_valid / out_stall) carries one unit normal per transaction, with
// normal_kind telling a face normal from a vertex normal. Loads give none.
// Items are handled one at a time; in_stall stays high from acceptance until
// the item is finished. Index reduction is skipped when the store depth is
// 4096 or more. Most of the work of a read or a triangle is the normalizer:
// up to 30 scaling steps, the sum of squares, 32 square root steps and 3 x 17
// division steps, one per cycle. A zero vector skips these steps and gives a
// zero normal. The three sum updates of a triangle are read-modify-writes on
// the sum memory, each a read state then a write state, done after the face
// normal is placed in the output register.
// A result waits in the output register while out_stall is high; the block
// holds before placing the next result until the register is free.
// Reset clears the control state only. Positions and sums are undefined
// until a vertex is loaded.
module mesh_vertex_normals_top import mvn_pkg::*; #(
	parameter int VERTEX_COUNT = MVN_VERTEX_COUNT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [IDX_W-1:0]        vertex_index,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [IDX_W-1:0]        corner_a,
	input  logic [IDX_W-1:0]        corner_b,
	input  logic [IDX_W-1:0]        corner_c,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [NRM_W-1:0] normal_x,
	output logic signed [NRM_W-1:0] normal_y,
	output logic signed [NRM_W-1:0] normal_z,
	output logic                    normal_kind
);

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam int WW = (AW > IDX_W) ? AW : IDX_W;

	// Number of compare-subtract steps that reduce an index below the depth.
	function automatic int red_steps_f();
		int n;
		n = 0;
		while ((VERTEX_COUNT << n) <= ((1 << IDX_W) - 1)) begin
			n++;
		end
		return n;
	endfunction

	localparam int RED_STEPS = red_steps_f();
	localparam int RW = $clog2(RED_STEPS + 2);

	function automatic logic [AW-1:0] addr_f(input logic [IDX_W-1:0] i);
		logic [WW-1:0] e;
		e = WW'(i);
		return e[AW-1:0];
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE, ST_REDUCE, ST_DISPATCH, ST_TRD_A, ST_TRD_B, ST_TRD_C, ST_TRD_D,
		ST_MUL, ST_VRD, ST_VWAIT, ST_NSTART, ST_NWAIT, ST_EMIT, ST_SRD, ST_SWR
	} state_t;

	state_t                   state_q;
	logic [1:0]               act_q;
	logic [IDX_W-1:0]         idx_q [4];
	pos_t                     pin_q;
	pos_t                     pa_q;
	pos_t                     pb_q;
	pos_t                     pc_q;
	logic [RW-1:0]            red_q;
	logic [2:0]               cnt_q;
	logic [1:0]               ci_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [VEC_W-1:0]  vec_q [3];
	logic signed [NRM_W-1:0]  nrm_q [3];
	logic                     out_valid_q;
	logic signed [NRM_W-1:0]  nx_q;
	logic signed [NRM_W-1:0]  ny_q;
	logic signed [NRM_W-1:0]  nz_q;
	logic                     kind_q;

	// Memories and their ports.
	pos_t            pos_mem [VERTEX_COUNT];
	sum_t            sum_mem [VERTEX_COUNT];
	pos_t            pos_rd;
	sum_t            sum_rd;
	logic [AW-1:0]   pos_raddr;
	logic [AW-1:0]   sum_raddr;
	logic            pos_we;
	logic            sum_we;
	logic [AW-1:0]   wr_addr;
	sum_t            sum_wdata;

	logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
	logic signed [EDGE_W-1:0] ma, mb;
	logic signed [PROD_W-1:0] mprod;
	logic [1:0]               vsel;
	logic [31:0]              dvs;
	logic [IDX_W-1:0]         corner;
	norm_req_t                nreq;
	norm_res_t                nres;
	logic                     in_acc;
	logic                     out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// Edges from corner A and the shared multiplier operands.
	always_comb begin
		e1x = {pb_q.x[POS_W-1], pb_q.x} - {pa_q.x[POS_W-1], pa_q.x};
		e1y = {pb_q.y[POS_W-1], pb_q.y} - {pa_q.y[POS_W-1], pa_q.y};
		e1z = {pb_q.z[POS_W-1], pb_q.z} - {pa_q.z[POS_W-1], pa_q.z};
		e2x = {pc_q.x[POS_W-1], pc_q.x} - {pa_q.x[POS_W-1], pa_q.x};
		e2y = {pc_q.y[POS_W-1], pc_q.y} - {pa_q.y[POS_W-1], pa_q.y};
		e2z = {pc_q.z[POS_W-1], pc_q.z} - {pa_q.z[POS_W-1], pa_q.z};
		case (cnt_q)
			3'd0: begin ma = e1y; mb = e2z; end
			3'd1: begin ma = e1z; mb = e2y; end
			3'd2: begin ma = e1z; mb = e2x; end
			3'd3: begin ma = e1x; mb = e2z; end
			3'd4: begin ma = e1x; mb = e2y; end
			default: begin ma = e1y; mb = e2x; end
		endcase
		mprod = ma * mb;
		// Cross product component that the previous product belongs to.
		vsel = 2'((cnt_q - 3'd1) >> 1);
	end

	// Memory addresses and write data.
	always_comb begin
		case (ci_q)
			2'd0: corner = idx_q[1];
			2'd1: corner = idx_q[2];
			default: corner = idx_q[3];
		endcase
		case (state_q)
			ST_TRD_B: pos_raddr = addr_f(idx_q[2]);
			ST_TRD_C: pos_raddr = addr_f(idx_q[3]);
			default:  pos_raddr = addr_f(idx_q[1]);
		endcase
		sum_raddr = (state_q == ST_VRD) ? addr_f(idx_q[0]) : addr_f(corner);
		pos_we = (state_q == ST_DISPATCH) && (act_q == ACT_LOAD);
		sum_we = pos_we || (state_q == ST_SWR);
		wr_addr = pos_we ? addr_f(idx_q[0]) : addr_f(corner);
		if (pos_we) begin
			sum_wdata = '0;
		end else begin
			sum_wdata.x = sat_add(sum_rd.x, nrm_q[0]);
			sum_wdata.y = sat_add(sum_rd.y, nrm_q[1]);
			sum_wdata.z = sat_add(sum_rd.z, nrm_q[2]);
		end
		dvs = 32'(VERTEX_COUNT) << (red_q - RW'(1));
	end

	// Position store.
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[wr_addr] <= pin_q;
		end
		pos_rd <= pos_mem[pos_raddr];
	end

	// Normal sum store.
	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[wr_addr] <= sum_wdata;
		end
		sum_rd <= sum_mem[sum_raddr];
	end

	assign nreq.start = (state_q == ST_NSTART);
	assign nreq.x     = vec_q[0];
	assign nreq.y     = vec_q[1];
	assign nreq.z     = vec_q[2];

	mvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nreq),
		.res    (nres)
	);

	// Item sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one taken in the same cycle.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						act_q <= action;
						idx_q[0] <= vertex_index;
						idx_q[1] <= corner_a;
						idx_q[2] <= corner_b;
						idx_q[3] <= corner_c;
						pin_q <= '{x: pos_x, y: pos_y, z: pos_z};
						red_q <= RW'(RED_STEPS);
						state_q <= (RED_STEPS > 0) ? ST_REDUCE : ST_DISPATCH;
					end
				end
				ST_REDUCE: begin
					// Indices beyond the depth wrap around.
					for (int i = 0; i < 4; i++) begin
						if (32'(idx_q[i]) >= dvs) begin
							idx_q[i] <= idx_q[i] - dvs[IDX_W-1:0];
						end
					end
					red_q <= red_q - RW'(1);
					if (red_q == RW'(1)) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					case (act_q)
						ACT_TRI:  state_q <= ST_TRD_A;
						ACT_READ: state_q <= ST_VRD;
						default:  state_q <= ST_IDLE;
					endcase
				end
				ST_TRD_A: state_q <= ST_TRD_B;
				ST_TRD_B: begin
					pa_q <= pos_rd;
					state_q <= ST_TRD_C;
				end
				ST_TRD_C: begin
					pb_q <= pos_rd;
					state_q <= ST_TRD_D;
				end
				ST_TRD_D: begin
					pc_q <= pos_rd;
					cnt_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// Six products through one multiplier, folded in pairs.
					prod_q <= mprod;
					if (cnt_q != 3'd0) begin
						if (cnt_q[0]) begin
							vec_q[vsel] <=
								{{(VEC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
						end else begin
							vec_q[vsel] <= vec_q[vsel]
								- {{(VEC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
						end
					end
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						state_q <= ST_NSTART;
					end
				end
				ST_VRD: state_q <= ST_VWAIT;
				ST_VWAIT: begin
					vec_q[0] <= {{(VEC_W-SUM_W){sum_rd.x[SUM_W-1]}}, sum_rd.x};
					vec_q[1] <= {{(VEC_W-SUM_W){sum_rd.y[SUM_W-1]}}, sum_rd.y};
					vec_q[2] <= {{(VEC_W-SUM_W){sum_rd.z[SUM_W-1]}}, sum_rd.z};
					state_q <= ST_NSTART;
				end
				ST_NSTART: state_q <= ST_NWAIT;
				ST_NWAIT: begin
					if (nres.done) begin
						nrm_q[0] <= nres.x;
						nrm_q[1] <= nres.y;
						nrm_q[2] <= nres.z;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						nx_q <= nrm_q[0];
						ny_q <= nrm_q[1];
						nz_q <= nrm_q[2];
						kind_q <= (act_q == ACT_TRI) ? KIND_FACE : KIND_VERTEX;
						ci_q <= '0;
						state_q <= (act_q == ACT_TRI) ? ST_SRD : ST_IDLE;
					end
				end
				ST_SRD: state_q <= ST_SWR;
				ST_SWR: begin
					// The write lands before the next corner is read.
					ci_q <= ci_q + 2'd1;
					state_q <= (ci_q == 2'd2) ? ST_IDLE : ST_SRD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign normal_x    = nx_q;
	assign normal_y    = ny_q;
	assign normal_z    = nz_q;
	assign normal_kind = kind_q;

`ifndef SYNTHESIS
	// The normalizer is only started while it is free.
	a_norm_free: assert property (@(posedge clk) disable iff (!arst_n)
		nreq.start |-> !nres.busy)
		else $error("normalizer started while busy");

	// A normalizer result arrives only while the sequencer waits for it.
	a_norm_wait: assert property (@(posedge clk) disable iff (!arst_n)
		nres.done |-> (state_q == ST_NWAIT))
		else $error("normalizer result not awaited");

	// A new result never overwrites one the receiver has not taken.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");

	// An accepted item always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("accepted item dropped");
`endif

endmodule

/* tb/mesh_vertex_normals_top_tb.sv */
// Self-checking testbench for the mesh vertex normal block with its own normal predictor.
`timescale 1ns / 1ps

module mesh_vertex_normals_top_tb;
	import mvn_pkg::*;

	localparam int NUM_VERTS = MVN_VERTEX_COUNT;

	typedef struct {
		logic [1:0]              act;
		logic [IDX_W-1:0]        idx;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic [IDX_W-1:0]        ca;
		logic [IDX_W-1:0]        cb;
		logic [IDX_W-1:0]        cc;
	} mesh_item_t;

	typedef struct {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
		logic                    kind;
	} normal_t;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              action;
	logic [IDX_W-1:0]        vertex_index;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [IDX_W-1:0]        corner_a;
	logic [IDX_W-1:0]        corner_b;
	logic [IDX_W-1:0]        corner_c;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [NRM_W-1:0] normal_x;
	logic signed [NRM_W-1:0] normal_y;
	logic signed [NRM_W-1:0] normal_z;
	logic                    normal_kind;

	// Predicted mesh state; only loaded vertices are ever touched.
	int      vert_x [NUM_VERTS];
	int      vert_y [NUM_VERTS];
	int      vert_z [NUM_VERTS];
	int      sum_x [NUM_VERTS];
	int      sum_y [NUM_VERTS];
	int      sum_z [NUM_VERTS];
	bit      is_loaded [NUM_VERTS];
	int      loaded_verts[$];
	normal_t pending_normals[$];

	int errors;
	int sender_idle_pct;
	int stall_pct;
	bit hold_on;

	mesh_vertex_normals_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.vertex_index(vertex_index),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.corner_a(corner_a),
		.corner_b(corner_b),
		.corner_c(corner_c),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.normal_kind(normal_kind)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Integer square root, floor, bit by bit.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Scale a vector to unit length in Q1.15, keeping the component signs.
	function automatic normal_t unit_normal(input longint vx, input longint vy,
			input longint vz, input logic kind);
		longint      v [3];
		logic [63:0] m [3];
		logic [63:0] mx;
		logic [63:0] sq;
		logic [63:0] len;
		logic [63:0] q;
		int          r [3];
		normal_t     n;
		v[0] = vx;
		v[1] = vy;
		v[2] = vz;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? -v[i] : v[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			r = '{0, 0, 0};
		end else begin
			while (mx >= (64'd1 << 31)) begin
				for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
				mx = mx >> 1;
			end
			while (mx < (64'd1 << 30)) begin
				for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
				mx = mx << 1;
			end
			sq = 0;
			for (int i = 0; i < 3; i++) sq = sq + m[i] * m[i];
			len = floor_sqrt(sq);
			for (int i = 0; i < 3; i++) begin
				q = (m[i] * 64'd32768 + len / 2) / len;
				if (q > 64'd32767) q = 64'd32767;
				r[i] = (v[i] < 0) ? -int'(q) : int'(q);
			end
		end
		n.x = NRM_W'(r[0]);
		n.y = NRM_W'(r[1]);
		n.z = NRM_W'(r[2]);
		n.kind = kind;
		return n;
	endfunction

	function automatic int clamp_add(input int a, input int b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return int'(s);
	endfunction

	// Update the predicted mesh for one accepted transaction and queue its normal.
	task automatic predict_normal(input mesh_item_t it);
		longint  e1 [3];
		longint  e2 [3];
		int      k [3];
		normal_t n;
		case (it.act)
			ACT_LOAD: begin
				vert_x[it.idx] = it.px;
				vert_y[it.idx] = it.py;
				vert_z[it.idx] = it.pz;
				sum_x[it.idx] = 0;
				sum_y[it.idx] = 0;
				sum_z[it.idx] = 0;
				if (!is_loaded[it.idx]) begin
					is_loaded[it.idx] = 1'b1;
					loaded_verts = {loaded_verts, int'(it.idx)};
				end
			end
			ACT_TRI: begin
				k = '{int'(it.ca), int'(it.cb), int'(it.cc)};
				e1[0] = longint'(vert_x[k[1]]) - vert_x[k[0]];
				e1[1] = longint'(vert_y[k[1]]) - vert_y[k[0]];
				e1[2] = longint'(vert_z[k[1]]) - vert_z[k[0]];
				e2[0] = longint'(vert_x[k[2]]) - vert_x[k[0]];
				e2[1] = longint'(vert_y[k[2]]) - vert_y[k[0]];
				e2[2] = longint'(vert_z[k[2]]) - vert_z[k[0]];
				n = unit_normal(e1[1] * e2[2] - e1[2] * e2[1],
					e1[2] * e2[0] - e1[0] * e2[2],
					e1[0] * e2[1] - e1[1] * e2[0], KIND_FACE);
				for (int i = 0; i < 3; i++) begin
					sum_x[k[i]] = clamp_add(sum_x[k[i]], n.x);
					sum_y[k[i]] = clamp_add(sum_y[k[i]], n.y);
					sum_z[k[i]] = clamp_add(sum_z[k[i]], n.z);
				end
				pending_normals = {pending_normals, n};
			end
			ACT_READ: begin
				n = unit_normal(sum_x[it.idx], sum_y[it.idx], sum_z[it.idx], KIND_VERTEX);
				pending_normals = {pending_normals, n};
			end
			default: begin
			end
		endcase
	endtask

	// Offer one item, with random sender gaps, and wait until it is accepted.
	task automatic send_item(input mesh_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= it.act;
		vertex_index <= it.idx;
		pos_x        <= it.px;
		pos_y        <= it.py;
		pos_z        <= it.pz;
		corner_a     <= it.ca;
		corner_b     <= it.cb;
		corner_c     <= it.cc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_normal(it);
	endtask

	function automatic mesh_item_t make_item(input logic [1:0] act, input int idx,
			input int px, input int py, input int pz, input int ca, input int cb, input int cc);
		mesh_item_t it;
		it.act = act;
		it.idx = IDX_W'(idx);
		it.px = POS_W'(px);
		it.py = POS_W'(py);
		it.pz = POS_W'(pz);
		it.ca = IDX_W'(ca);
		it.cb = IDX_W'(cb);
		it.cc = IDX_W'(cc);
		return it;
	endfunction

	function automatic int pick_loaded();
		return loaded_verts[$urandom_range(loaded_verts.size() - 1)];
	endfunction

	// Random item; triangles and reads only name loaded vertices.
	function automatic mesh_item_t random_item();
		mesh_item_t it;
		int         sel;
		int         span;
		it.idx = IDX_W'($urandom);
		it.px = POS_W'($urandom);
		it.py = POS_W'($urandom);
		it.pz = POS_W'($urandom);
		it.ca = IDX_W'($urandom);
		it.cb = IDX_W'($urandom);
		it.cc = IDX_W'($urandom);
		sel = $urandom_range(99);
		if (loaded_verts.size() < 3 || sel < 28) begin
			it.act = ACT_LOAD;
			if (loaded_verts.size() > 0 && $urandom_range(3) == 0) begin
				it.idx = IDX_W'(pick_loaded());
			end
			// Mostly small meshes so that normals vary; sometimes full range.
			if ($urandom_range(2) != 0) begin
				span = 1 << $urandom_range(16, 4);
				it.px = POS_W'($urandom_range(2 * span) - span);
				it.py = POS_W'($urandom_range(2 * span) - span);
				it.pz = POS_W'($urandom_range(2 * span) - span);
			end
		end else if (sel < 75) begin
			it.act = ACT_TRI;
			it.ca = IDX_W'(pick_loaded());
			it.cb = IDX_W'(pick_loaded());
			it.cc = ($urandom_range(9) == 0) ? it.ca : IDX_W'(pick_loaded());
		end else if (sel < 96) begin
			it.act = ACT_READ;
			it.idx = IDX_W'(pick_loaded());
		end else begin
			it.act = ACT_UNUSED;
		end
		return it;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		normal_t n;
		if (out_valid && !out_stall) begin
			if (pending_normals.size() == 0) begin
				$display("%0t: expected no normal, actual (%0d,%0d,%0d) kind %0d", $time,
					normal_x, normal_y, normal_z, normal_kind);
				errors++;
			end else begin
				n = pending_normals.pop_front();
				if (normal_x !== n.x) begin
					$display("%0t: normal_x expected %0d actual %0d", $time, n.x, normal_x);
					errors++;
				end
				if (normal_y !== n.y) begin
					$display("%0t: normal_y expected %0d actual %0d", $time, n.y, normal_y);
					errors++;
				end
				if (normal_z !== n.z) begin
					$display("%0t: normal_z expected %0d actual %0d", $time, n.z, normal_z);
					errors++;
				end
				if (normal_kind !== n.kind) begin
					$display("%0t: normal_kind expected %0d actual %0d", $time, n.kind,
						normal_kind);
					errors++;
				end
			end
		end
	end

	// Receiver stall generator; a long hold overrides the random stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_on) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Extremes, degenerate triangles, unused action and reload clearing sums.
	task automatic test_directed();
		localparam int PMAX = 8388607;
		localparam int PMIN = -8388608;
		sender_idle_pct = 0;
		stall_pct = 0;
		send_item(make_item(ACT_LOAD, 0, PMIN, PMIN, PMIN, 4095, 0, 4095));
		send_item(make_item(ACT_LOAD, 4095, PMAX, PMIN, PMIN, 0, 4095, 0));
		send_item(make_item(ACT_LOAD, 1, PMIN, PMAX, PMIN, 0, 0, 0));
		send_item(make_item(ACT_LOAD, 2, PMIN, PMIN, PMAX, 0, 0, 0));
		send_item(make_item(ACT_LOAD, 3, 256, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_LOAD, 4, 0, 256, 0, 0, 0, 0));
		send_item(make_item(ACT_READ, 0, PMAX, PMAX, PMAX, 4095, 4095, 4095));
		send_item(make_item(ACT_TRI, 4095, 0, 0, 0, 0, 4095, 1));
		send_item(make_item(ACT_TRI, 0, 0, 0, 0, 0, 1, 2));
		send_item(make_item(ACT_TRI, 0, 0, 0, 0, 4095, 1, 2));
		send_item(make_item(ACT_TRI, 0, 0, 0, 0, 0, 3, 4));
		send_item(make_item(ACT_TRI, 0, 0, 0, 0, 0, 0, 1));
		send_item(make_item(ACT_TRI, 0, 0, 0, 0, 3, 3, 3));
		send_item(make_item(ACT_UNUSED, 4095, PMAX, PMIN, -1, 4095, 4095, 4095));
		send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_READ, 4095, 0, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_READ, 1, 0, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_READ, 2, 0, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_READ, 3, 0, 0, 0, 0, 0, 0));
		send_item(make_item(ACT_LOAD, 0, 1, -1, 0, 0, 0, 0));
		send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random(input int count, input int idle_pct, input int stall_p);
		sender_idle_pct = idle_pct;
		stall_pct = stall_p;
		repeat (count) send_item(random_item());
	endtask

	// Receiver holds off for a long stretch while items keep coming.
	task automatic test_backpressure();
		sender_idle_pct = 0;
		stall_pct = 0;
		fork
			begin
				hold_on = 1'b1;
				repeat (600) @(posedge clk);
				hold_on = 1'b0;
			end
		join_none
		repeat (20) send_item(random_item());
	endtask

	initial begin
		errors = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		action       <= ACT_LOAD;
		vertex_index <= '0;
		pos_x        <= '0;
		pos_y        <= '0;
		pos_z        <= '0;
		corner_a     <= '0;
		corner_b     <= '0;
		corner_c     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(130, 0, 0);
		test_random(130, 60, 0);
		test_random(130, 0, 60);
		test_random(120, 8, 8);
		test_backpressure();
		test_random(20, 0, 0);

		in_valid <= 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("mesh_vertex_normals_top: match");
		end else begin
			$display("mesh_vertex_normals_top: mismatch");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5000000;
		$display("mesh_vertex_normals_top: mismatch");
		$finish;
	end

endmodule
